// ===== design/cfr_pkg.sv =====
// Shared types and constants of the CAN frame reassembler.
`timescale 1ns / 1ps
package cfr_pkg;

	localparam int LANES   = 8;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = LANES * BYTE_W;
	localparam int NUM_CH  = 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_UPGRADE_CODE = 2'd0;
	localparam logic [1:0] REG_PANEL_SRC    = 2'd1;
	localparam logic [1:0] REG_BOARD_LIMIT  = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_WRONG_SRC  = 3'd1;
	localparam logic [2:0] ERR_SRC_CHANGE = 3'd2;
	localparam logic [2:0] ERR_SEQ_GAP    = 3'd3;
	localparam logic [2:0] ERR_LENGTH     = 3'd4;
	localparam logic [2:0] ERR_FULL_START = 3'd5;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd6;

	localparam logic KIND_ERROR = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	typedef struct packed {
		logic [7:0] upgrade_code;
		logic [7:0] panel_src;
		logic [7:0] board_limit;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_READ,
		ST_EMIT
	} state_t;

endpackage

// ===== design/cfr_regs.sv =====
// APB configuration registers of the CAN frame reassembler.
`timescale 1ns / 1ps
module cfr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfr_pkg::PADDR_W-1:0] paddr,
	input  logic [cfr_pkg::PDATA_W-1:0] pwdata,
	output logic [cfr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output cfr_pkg::cfg_t               cfg
);

	cfr_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				cfr_pkg::REG_UPGRADE_CODE: cfg_q.upgrade_code <= pwdata[7:0];
				cfr_pkg::REG_PANEL_SRC:    cfg_q.panel_src    <= pwdata[7:0];
				cfr_pkg::REG_BOARD_LIMIT:  cfg_q.board_limit  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cfr_pkg::REG_UPGRADE_CODE: prdata = {24'd0, cfg_q.upgrade_code};
			cfr_pkg::REG_PANEL_SRC:    prdata = {24'd0, cfg_q.panel_src};
			cfr_pkg::REG_BOARD_LIMIT:  prdata = {24'd0, cfg_q.board_limit};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== design/cfr_buf.sv =====
// Packet byte buffer: eight byte lanes, each lane written at its own row, read as one row.
`timescale 1ns / 1ps
module cfr_buf #(
	parameter int ADDR_W = 6
) (
	input  logic                                     clk,
	input  logic [cfr_pkg::LANES-1:0]                wr_en,
	input  logic [cfr_pkg::LANES-1:0][ADDR_W-1:0]    wr_addr,
	input  logic [cfr_pkg::LANES-1:0][cfr_pkg::BYTE_W-1:0] wr_data,
	input  logic                                     rd_en,
	input  logic [ADDR_W-1:0]                        rd_addr,
	output logic [cfr_pkg::WORD_W-1:0]               rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	for (genvar b = 0; b < cfr_pkg::LANES; b++) begin : g_lane
		logic [cfr_pkg::BYTE_W-1:0] mem [DEPTH];
		logic [cfr_pkg::BYTE_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr_en[b]) begin
				mem[wr_addr[b]] <= wr_data[b];
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr];
			end
		end

		assign rd_data[b*cfr_pkg::BYTE_W +: cfr_pkg::BYTE_W] = rd_q;
	end

endmodule

// ===== design/cfr_ctrl.sv =====
// Frame checker, channel contexts, buffer write and packet word sequencer.
`timescale 1ns / 1ps
module cfr_ctrl #(
	parameter int  MAX_PACKET_BYTES = 256,
	localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1),
	localparam int ROW_N = (MAX_PACKET_BYTES + 7) / 8,
	localparam int ROW_W = (ROW_N > 1) ? $clog2(ROW_N) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfr_pkg::cfg_t         cfg,
	input  logic                  start,
	output logic                  busy,
	input  logic                  channel,
	input  logic [7:0]            source_addr,
	input  logic [7:0]            cmd_code,
	input  logic [7:0]            seq_id,
	input  logic                  last_frame,
	input  logic [3:0]            data_length,
	input  logic [63:0]           frame_data,
	output logic [cfr_pkg::LANES-1:0] wr_en,
	output logic [cfr_pkg::LANES-1:0][ROW_W:0] wr_addr,
	output logic [cfr_pkg::LANES-1:0][cfr_pkg::BYTE_W-1:0] wr_data,
	output logic                  rd_en,
	output logic [ROW_W:0]        rd_addr,
	input  logic [63:0]           rd_data,
	output logic                  strobe,
	output logic                  kind,
	output logic [2:0]            error_code,
	output logic [63:0]           packet_word,
	output logic [3:0]            word_bytes,
	output logic [LEN_W-1:0]      packet_length,
	output logic [7:0]            packet_source,
	output logic                  out_channel,
	output logic                  last
);

	localparam logic [LEN_W:0] MAX_L = (LEN_W + 1)'(MAX_PACKET_BYTES);

	cfr_pkg::state_t state_q, state_d;

	logic             ch_q;
	logic [7:0]       src_q;
	logic [7:0]       code_q;
	logic [7:0]       seq_q;
	logic             lastf_q;
	logic [3:0]       dlen_q;
	logic [63:0]      data_q;

	logic [LEN_W-1:0] len_q  [cfr_pkg::NUM_CH];
	logic [7:0]       exp_q  [cfr_pkg::NUM_CH];
	logic [7:0]       lsrc_q [cfr_pkg::NUM_CH];

	logic [LEN_W-1:0] emit_len_q;
	logic [LEN_W-1:0] pos_q;

	logic             strobe_q;
	logic             kind_q;
	logic [2:0]       err_q;
	logic [63:0]      word_q;
	logic [3:0]       bytes_q;
	logic [LEN_W-1:0] plen_q;
	logic [7:0]       psrc_q;
	logic             pch_q;
	logic             plast_q;

	logic             accept;
	logic [LEN_W-1:0] cur_len;
	logic [7:0]       cur_exp;
	logic [7:0]       cur_lsrc;
	logic             match;
	logic             src_ok;
	logic             is_start;
	logic [2:0]       ctx_err;
	logic [LEN_W-1:0] base_len;
	logic             full;
	logic             len_bad;
	logic [LEN_W:0]   space;
	logic [LEN_W:0]   dlen_ext;
	logic [LEN_W:0]   sum_len;
	logic             ovf;
	logic [LEN_W-1:0] len_after;
	logic             copy_ok;
	logic [2:0]       lane_off [cfr_pkg::LANES];
	logic [LEN_W:0]   lane_pos [cfr_pkg::LANES];
	logic [LEN_W-1:0] remain;
	logic [3:0]       cnt;
	logic             emit_done;

	logic             ctx_upd;
	logic [LEN_W-1:0] len_new;
	logic             res_valid;
	logic             res_kind;
	logic [2:0]       res_err;
	logic [63:0]      res_word;
	logic [3:0]       res_bytes;
	logic [LEN_W-1:0] res_len;
	logic [7:0]       res_src;
	logic             res_last;
	logic             load_emit;
	logic             pos_step;

	assign busy   = (state_q != cfr_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign cur_len  = len_q[ch_q];
	assign cur_exp  = exp_q[ch_q];
	assign cur_lsrc = lsrc_q[ch_q];

	assign match    = (code_q == cfg.upgrade_code);
	assign src_ok   = ch_q ? (src_q == cfg.panel_src) : (src_q < cfg.board_limit);
	assign is_start = (seq_q == 8'd0);

	always_comb begin
		if (is_start) begin
			ctx_err = cfr_pkg::ERR_NONE;
		end else if (cur_lsrc != src_q) begin
			ctx_err = cfr_pkg::ERR_SRC_CHANGE;
		end else if (cur_exp != seq_q) begin
			ctx_err = cfr_pkg::ERR_SEQ_GAP;
		end else begin
			ctx_err = cfr_pkg::ERR_NONE;
		end
	end

	assign base_len  = is_start ? '0 : cur_len;
	assign full      = ({1'b0, base_len} >= MAX_L);
	assign len_bad   = (dlen_q > 4'd8);
	assign space     = MAX_L - {1'b0, base_len};
	assign dlen_ext  = (LEN_W + 1)'(dlen_q);
	assign sum_len   = {1'b0, base_len} + dlen_ext;
	assign ovf       = (dlen_ext > space);
	assign len_after = ovf ? '0 : sum_len[LEN_W-1:0];
	assign copy_ok   = match && src_ok && (ctx_err == cfr_pkg::ERR_NONE) && !len_bad && !full;

	assign remain    = emit_len_q - pos_q;
	assign emit_done = (remain <= LEN_W'(8));
	assign cnt       = emit_done ? remain[3:0] : 4'd8;

	always_comb begin
		for (int b = 0; b < cfr_pkg::LANES; b++) begin
			lane_off[b] = 3'(b) - base_len[2:0];
			lane_pos[b] = {1'b0, base_len} + (LEN_W + 1)'(lane_off[b]);
			wr_en[b]    = (state_q == cfr_pkg::ST_PROC) && copy_ok
				&& ({1'b0, lane_off[b]} < dlen_q) && (lane_pos[b] < MAX_L);
			wr_addr[b]  = {ch_q, ROW_W'(lane_pos[b] >> 3)};
			wr_data[b]  = data_q[{lane_off[b], 3'b000} +: 8];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfr_pkg::ST_IDLE: begin
				if (start) begin
					state_d = cfr_pkg::ST_PROC;
				end
			end
			cfr_pkg::ST_PROC: begin
				state_d = (copy_ok && lastf_q) ? cfr_pkg::ST_READ : cfr_pkg::ST_IDLE;
			end
			cfr_pkg::ST_READ: begin
				state_d = cfr_pkg::ST_EMIT;
			end
			cfr_pkg::ST_EMIT: begin
				state_d = emit_done ? cfr_pkg::ST_IDLE : cfr_pkg::ST_READ;
			end
			default: begin
				state_d = cfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctx_upd   = 1'b0;
		len_new   = base_len;
		res_valid = 1'b0;
		res_kind  = cfr_pkg::KIND_ERROR;
		res_err   = cfr_pkg::ERR_NONE;
		res_word  = '0;
		res_bytes = '0;
		res_len   = '0;
		res_src   = src_q;
		res_last  = 1'b1;
		load_emit = 1'b0;
		pos_step  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {ch_q, ROW_W'(pos_q >> 3)};
		case (state_q)
			cfr_pkg::ST_PROC: begin
				if (match) begin
					if (!src_ok) begin
						res_valid = 1'b1;
						res_err   = cfr_pkg::ERR_WRONG_SRC;
					end else if (ctx_err != cfr_pkg::ERR_NONE) begin
						res_valid = 1'b1;
						res_err   = ctx_err;
					end else if (len_bad) begin
						ctx_upd   = 1'b1;
						res_valid = 1'b1;
						res_err   = cfr_pkg::ERR_LENGTH;
					end else if (full) begin
						ctx_upd   = 1'b1;
						len_new   = '0;
						res_valid = 1'b1;
						res_err   = cfr_pkg::ERR_FULL_START;
					end else begin
						ctx_upd   = 1'b1;
						len_new   = lastf_q ? '0 : len_after;
						load_emit = 1'b1;
						res_valid = ovf;
						res_err   = cfr_pkg::ERR_OVERFLOW;
						res_last  = !lastf_q;
					end
				end
			end
			cfr_pkg::ST_READ: begin
				rd_en = 1'b1;
			end
			cfr_pkg::ST_EMIT: begin
				pos_step  = 1'b1;
				res_valid = 1'b1;
				res_kind  = cfr_pkg::KIND_DATA;
				res_bytes = cnt;
				res_len   = emit_len_q;
				res_src   = cur_lsrc;
				res_last  = emit_done;
				for (int b = 0; b < cfr_pkg::LANES; b++) begin
					res_word[b*8 +: 8] = (4'(b) < cnt) ? rd_data[b*8 +: 8] : 8'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cfr_pkg::ST_IDLE;
			strobe_q <= 1'b0;
			for (int c = 0; c < cfr_pkg::NUM_CH; c++) begin
				len_q[c]  <= '0;
				exp_q[c]  <= '0;
				lsrc_q[c] <= '0;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= res_valid;
			if (ctx_upd) begin
				len_q[ch_q]  <= len_new;
				exp_q[ch_q]  <= is_start ? 8'd1 : cur_exp + 8'd1;
				lsrc_q[ch_q] <= is_start ? src_q : cur_lsrc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q    <= channel;
			src_q   <= source_addr;
			code_q  <= cmd_code;
			seq_q   <= seq_id;
			lastf_q <= last_frame;
			dlen_q  <= data_length;
			data_q  <= frame_data;
		end
		if (load_emit) begin
			emit_len_q <= len_after;
			pos_q      <= '0;
		end else if (pos_step) begin
			pos_q <= pos_q + LEN_W'(8);
		end
		if (res_valid) begin
			kind_q  <= res_kind;
			err_q   <= res_err;
			word_q  <= res_word;
			bytes_q <= res_bytes;
			plen_q  <= res_len;
			psrc_q  <= res_src;
			pch_q   <= ch_q;
			plast_q <= res_last;
		end
	end

	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign error_code    = err_q;
	assign packet_word   = word_q;
	assign word_bytes    = bytes_q;
	assign packet_length = plen_q;
	assign packet_source = psrc_q;
	assign out_channel   = pch_q;
	assign last          = plast_q;

endmodule

// ===== design/can_frame_reassembler.sv =====
// Top level of the CAN frame reassembler: registers, control and packet buffer.
//
// Channel   Handshake                         Beat
// config    psel, penable, pwrite, pready     paddr, pwdata, prdata
// frame in  start, busy (taken: start & !busy) channel .. frame_data
// result    strobe (one cycle, no stall)       kind .. last
//
// An accepted frame is evaluated in the cycle after acceptance; busy is high from then on.
// Ignored, rejected and non-final frames return to idle straight after evaluation.
// A final frame then passes a read state and an emit state per packet word, set by the one-row read port of the buffer.
// Results are registered and appear in the cycle after they are formed; the receiver never stalls them.
// Reset clears the channel contexts and registers; the buffer itself needs no clearing.
`timescale 1ns / 1ps
module can_frame_reassembler #(
	parameter int  MAX_PACKET_BYTES = 256,
	localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfr_pkg::PADDR_W-1:0] paddr,
	input  logic [cfr_pkg::PDATA_W-1:0] pwdata,
	output logic [cfr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic                        channel,
	input  logic [7:0]                  source_addr,
	input  logic [7:0]                  cmd_code,
	input  logic [7:0]                  seq_id,
	input  logic                        last_frame,
	input  logic [3:0]                  data_length,
	input  logic [63:0]                 frame_data,
	output logic                        strobe,
	output logic                        kind,
	output logic [2:0]                  error_code,
	output logic [63:0]                 packet_word,
	output logic [3:0]                  word_bytes,
	output logic [LEN_W-1:0]            packet_length,
	output logic [7:0]                  packet_source,
	output logic                        out_channel,
	output logic                        last
);

	localparam int ROW_N  = (MAX_PACKET_BYTES + 7) / 8;
	localparam int ROW_W  = (ROW_N > 1) ? $clog2(ROW_N) : 1;
	localparam int ADDR_W = ROW_W + 1;

	cfr_pkg::cfg_t cfg;
	logic [cfr_pkg::LANES-1:0]                     wr_en;
	logic [cfr_pkg::LANES-1:0][ADDR_W-1:0]         wr_addr;
	logic [cfr_pkg::LANES-1:0][cfr_pkg::BYTE_W-1:0] wr_data;
	logic                                          rd_en;
	logic [ADDR_W-1:0]                             rd_addr;
	logic [cfr_pkg::WORD_W-1:0]                    rd_data;

	cfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfr_ctrl #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.start         (start),
		.busy          (busy),
		.channel       (channel),
		.source_addr   (source_addr),
		.cmd_code      (cmd_code),
		.seq_id        (seq_id),
		.last_frame    (last_frame),
		.data_length   (data_length),
		.frame_data    (frame_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.strobe        (strobe),
		.kind          (kind),
		.error_code    (error_code),
		.packet_word   (packet_word),
		.word_bytes    (word_bytes),
		.packet_length (packet_length),
		.packet_source (packet_source),
		.out_channel   (out_channel),
		.last          (last)
	);

	cfr_buf #(
		.ADDR_W (ADDR_W)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
